// File: sv/bmim_pkg.sv
// Shared types and constants for the beacon mesh ID matcher.
package bmim_pkg;

    localparam int MAX_FRAME_BYTES   = 4096;
    localparam int MAX_MESH_ID_BYTES = 32;
    localparam int POS_W             = 12;
    localparam int POS_CAP_INT       = (MAX_FRAME_BYTES - 1 < 4095) ? MAX_FRAME_BYTES - 1 : 4095;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

    // The expected ID bank always holds 32 bytes (four 64-bit registers).
    localparam int ID_BANK_BYTES = 32;

    localparam logic [7:0] EID_MESH_ID     = 8'd114;
    localparam logic [7:0] EID_MESH_CONFIG = 8'd113;

    localparam int ELEMENTS_START = 24 + 12;
    localparam int BSSID_FIRST    = 16;
    localparam int BSSID_END      = 22;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_ID_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES_0_7   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES_8_15  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES_16_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES_24_31 = 3'd4;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_ID     = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_VALUE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic             mesh_id_found;
        logic             mesh_id_matches;
        logic             mesh_config_found;
        logic [47:0]      bssid;
        logic             bssid_valid;
        logic [POS_W-1:0] frame_length;
    } t_out_item;

    typedef struct packed {
        logic [5:0]                   mesh_id_length;
        logic [ID_BANK_BYTES*8-1:0]   mesh_id_bytes;
    } t_cfg;

endpackage

// File: sv/beacon_mesh_id_matcher.sv
// Top level of the beacon mesh ID matcher: configuration bank, parser and result buffer.
//
// Feed a beacon frame one byte per transfer, with last_byte set on the final
// byte. The block captures the BSSID from frame bytes 16 to 21, skips the
// 36-byte fixed header, walks the element id/length records and reports the
// first complete Mesh ID (114) and Mesh Configuration (113) elements (the latter
// only alongside a complete Mesh ID). The Mesh ID value is checked byte by byte
// against the configured ID as it streams by; the length is checked at frame end.
// A byte can be taken in every cycle while o_stall is low. The frame result is
// loaded into the output register in the cycle after its last byte is taken when
// that register is free or being taken; when it still holds an earlier result,
// the new one waits in the skid entry until the sink takes the earlier one.
// Results leave through an output register backed by one skid entry, so input
// keeps flowing while one result waits; o_stall rises only when both entries hold
// results the sink has not taken. Write configuration only between frames, with no result pending.
module beacon_mesh_id_matcher (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // byte input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  bmim_pkg::t_in_item                    i_data,
    // frame result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output bmim_pkg::t_out_item                   o_data,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [bmim_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [63:0]                           i_cfg_data
);
    import bmim_pkg::*;

    t_cfg      r_cfg;
    logic      take;
    logic      res_valid;
    t_out_item res;

    logic      r_out_valid,  n_out_valid;
    t_out_item r_out,        n_out;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_skid,       n_skid;
    logic      out_take;

    // Configuration bank: plain writes, indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MESH_ID_LENGTH: r_cfg.mesh_id_length        <= i_cfg_data[5:0];
                CFG_ID_BYTES_0_7:   r_cfg.mesh_id_bytes[63:0]   <= i_cfg_data;
                CFG_ID_BYTES_8_15:  r_cfg.mesh_id_bytes[127:64] <= i_cfg_data;
                CFG_ID_BYTES_16_23: r_cfg.mesh_id_bytes[191:128] <= i_cfg_data;
                CFG_ID_BYTES_24_31: r_cfg.mesh_id_bytes[255:192] <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Stall input only while the skid entry is occupied; then a new result
    // always has a free slot.
    assign o_stall = r_skid_valid;
    assign take    = i_valid && !o_stall;

    bmim_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_item         (i_data),
        .i_cfg          (r_cfg),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    assign out_take = r_out_valid && !i_stall;

    // Output register plus skid: advance skid into the output when the
    // output frees up, park a new result in the skid when the output holds.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = res_valid;
                n_skid       = res;
            end else begin
                n_out_valid  = res_valid;
                n_out        = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    // The skid entry is filled only behind a held output result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A taken last byte always leaves a result on the output next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.last_byte) |=> o_valid)
        else $error("frame end produced no result");

    // A match implies the Mesh ID element was found.
    a_match_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.mesh_id_matches) |-> o_data.mesh_id_found)
        else $error("mesh ID match without mesh ID element");

    // BSSID validity follows the reported frame length.
    a_bssid_by_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.bssid_valid == (o_data.frame_length >= POS_W'(BSSID_END))))
        else $error("bssid_valid disagrees with frame_length");
`endif

endmodule

// File: sv/bmim_parser.sv
// Per-frame element walker: holds parse state, compares Mesh ID bytes, forms the frame result.
module bmim_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  bmim_pkg::t_in_item  i_item,
    input  bmim_pkg::t_cfg      i_cfg,
    output logic                o_result_valid,
    output bmim_pkg::t_out_item o_result
);
    import bmim_pkg::*;

    logic [POS_W-1:0] r_pos,        n_pos;
    t_phase           r_phase,      n_phase;
    logic [7:0]       r_elem_id,    n_elem_id;
    logic [7:0]       r_left,       n_left;
    logic             r_mesh_open,  n_mesh_open;
    logic             r_mesh_done,  n_mesh_done;
    logic [7:0]       r_mesh_len,   n_mesh_len;
    logic             r_mesh_equal, n_mesh_equal;
    logic             r_conf_open,  n_conf_open;
    logic             r_conf_done,  n_conf_done;
    logic [47:0]      r_bssid,      n_bssid;

    // Values after walking the current byte, before any end-of-frame clear.
    logic [POS_W-1:0] walk_pos;
    t_phase           walk_phase;
    logic [7:0]       walk_elem_id;
    logic [7:0]       walk_left;
    logic             walk_mesh_open;
    logic             walk_mesh_done;
    logic [7:0]       walk_mesh_len;
    logic             walk_mesh_equal;
    logic             walk_conf_open;
    logic             walk_conf_done;
    logic [47:0]      walk_bssid;

    logic [7:0] b;
    logic [7:0] k;
    logic [7:0] expected;
    logic [7:0] left_dec;
    logic       bvalid;

    assign b        = i_item.frame_byte;
    assign k        = r_mesh_len - r_left;
    assign expected = i_cfg.mesh_id_bytes[{k[4:0], 3'b000} +: 8];
    assign left_dec = r_left - 8'd1;

    always_comb begin
        walk_pos        = (r_pos < POS_CAP) ? r_pos + POS_W'(1) : r_pos;
        walk_phase      = r_phase;
        walk_elem_id    = r_elem_id;
        walk_left       = r_left;
        walk_mesh_open  = r_mesh_open;
        walk_mesh_done  = r_mesh_done;
        walk_mesh_len   = r_mesh_len;
        walk_mesh_equal = r_mesh_equal;
        walk_conf_open  = r_conf_open;
        walk_conf_done  = r_conf_done;
        walk_bssid      = r_bssid;

        if (r_pos >= POS_W'(BSSID_FIRST) && r_pos < POS_W'(BSSID_END)) begin
            walk_bssid = {r_bssid[39:0], b};
        end

        case (r_phase)
            PH_HEADER: begin
                if (r_pos >= POS_W'(ELEMENTS_START - 1)) begin
                    walk_phase = PH_ID;
                end
            end
            PH_ID: begin
                walk_elem_id = b;
                walk_phase   = PH_LEN;
            end
            PH_LEN: begin
                if (r_elem_id == EID_MESH_ID && !r_mesh_open && !r_mesh_done) begin
                    walk_mesh_len   = b;
                    walk_mesh_equal = 1'b1;
                    if (b == 8'd0) walk_mesh_done = 1'b1;
                    else           walk_mesh_open = 1'b1;
                end else if (r_elem_id == EID_MESH_CONFIG && !r_conf_open && !r_conf_done) begin
                    if (b == 8'd0) walk_conf_done = 1'b1;
                    else           walk_conf_open = 1'b1;
                end
                walk_left  = b;
                walk_phase = (b == 8'd0) ? PH_ID : PH_VALUE;
            end
            PH_VALUE: begin
                if (r_mesh_open) begin
                    if (k >= 8'(MAX_MESH_ID_BYTES) || k >= 8'(ID_BANK_BYTES) || expected != b) begin
                        walk_mesh_equal = 1'b0;
                    end
                end
                walk_left = left_dec;
                if (left_dec == 8'd0) begin
                    // Close whichever tracked element ends on this byte.
                    if (r_mesh_open) begin
                        walk_mesh_open = 1'b0;
                        walk_mesh_done = 1'b1;
                    end
                    if (r_conf_open) begin
                        walk_conf_open = 1'b0;
                        walk_conf_done = 1'b1;
                    end
                    walk_phase = PH_ID;
                end
            end
            default: begin
                walk_phase = r_phase;
            end
        endcase
    end

    assign bvalid = walk_pos >= POS_W'(BSSID_END);

    always_comb begin
        o_result_valid             = i_take && i_item.last_byte;
        o_result.mesh_id_found     = walk_mesh_done;
        o_result.mesh_id_matches   = walk_mesh_done && walk_mesh_equal
                                     && ({1'b0, i_cfg.mesh_id_length} <= 7'(MAX_MESH_ID_BYTES))
                                     && (walk_mesh_len == {2'b00, i_cfg.mesh_id_length});
        o_result.mesh_config_found = walk_mesh_done && walk_conf_done;
        o_result.bssid             = bvalid ? walk_bssid : 48'd0;
        o_result.bssid_valid       = bvalid;
        o_result.frame_length      = walk_pos;
    end

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_elem_id    = r_elem_id;
        n_left       = r_left;
        n_mesh_open  = r_mesh_open;
        n_mesh_done  = r_mesh_done;
        n_mesh_len   = r_mesh_len;
        n_mesh_equal = r_mesh_equal;
        n_conf_open  = r_conf_open;
        n_conf_done  = r_conf_done;
        n_bssid      = r_bssid;
        if (i_take) begin
            if (i_item.last_byte) begin
                // Frame done: drop all per-frame state.
                n_pos        = '0;
                n_phase      = PH_HEADER;
                n_elem_id    = '0;
                n_left       = '0;
                n_mesh_open  = 1'b0;
                n_mesh_done  = 1'b0;
                n_mesh_len   = '0;
                n_mesh_equal = 1'b1;
                n_conf_open  = 1'b0;
                n_conf_done  = 1'b0;
                n_bssid      = '0;
            end else begin
                n_pos        = walk_pos;
                n_phase      = walk_phase;
                n_elem_id    = walk_elem_id;
                n_left       = walk_left;
                n_mesh_open  = walk_mesh_open;
                n_mesh_done  = walk_mesh_done;
                n_mesh_len   = walk_mesh_len;
                n_mesh_equal = walk_mesh_equal;
                n_conf_open  = walk_conf_open;
                n_conf_done  = walk_conf_done;
                n_bssid      = walk_bssid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= PH_HEADER;
            r_elem_id    <= '0;
            r_left       <= '0;
            r_mesh_open  <= 1'b0;
            r_mesh_done  <= 1'b0;
            r_mesh_len   <= '0;
            r_mesh_equal <= 1'b1;
            r_conf_open  <= 1'b0;
            r_conf_done  <= 1'b0;
            r_bssid      <= '0;
        end else begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_elem_id    <= n_elem_id;
            r_left       <= n_left;
            r_mesh_open  <= n_mesh_open;
            r_mesh_done  <= n_mesh_done;
            r_mesh_len   <= n_mesh_len;
            r_mesh_equal <= n_mesh_equal;
            r_conf_open  <= n_conf_open;
            r_conf_done  <= n_conf_done;
            r_bssid      <= n_bssid;
        end
    end

endmodule

// File: bench/tb.sv
// Self-checking bench for the beacon mesh ID matcher: frame stimulus, stalls and a frame predictor.
module tb;
    import bmim_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int STRAY_MAX   = (1 << CFG_IDX_W) - 1;

    typedef enum int {RX_FREE, RX_LIGHT, RX_PATTERN, RX_HEAVY} t_rx_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_item             i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_item            o_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MESH_ID_LENGTH;
    logic [63:0]          i_cfg_data  = '0;

    beacon_mesh_id_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock, period 2.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor: a copy of the parser state and of the configured ID.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]           pos_cnt;
    t_phase                     walk_phase;
    logic [7:0]                 elem_id;
    logic [7:0]                 bytes_left;
    logic [7:0]                 mesh_len;
    logic                       mesh_open;
    logic                       mesh_done;
    logic                       mesh_equal;
    logic                       meshcfg_open;
    logic                       meshcfg_done;
    logic [47:0]                bssid_shift;
    logic [5:0]                 cfg_id_len;
    logic [ID_BANK_BYTES*8-1:0] cfg_id_bytes;

    t_out_item  expected_reports[$];   // frame results still owed by the block
    t_in_item   pending_bytes[$];      // byte transfers not yet taken by the block
    logic [7:0] frame_buf[$];          // frame under construction

    int       fail_count   = 0;
    int       cycle_count  = 0;
    int       phase_items  = 0;
    int       phase_frames = 0;
    bit       byte_taken   = 1'b0;
    int       gap_left     = 0;
    int       burst_left   = 1;
    int       holds_asked  = 0;
    int       holds_given  = 0;
    int       hold_left    = 0;
    int       mode_left    = 0;
    t_rx_mode rx_mode      = RX_FREE;
    logic [7:0] rx_pattern = 8'h00;

    task automatic clear_frame_state();
        pos_cnt      = '0;
        walk_phase   = PH_HEADER;
        elem_id      = '0;
        bytes_left   = '0;
        mesh_len     = '0;
        mesh_open    = 1'b0;
        mesh_done    = 1'b0;
        mesh_equal   = 1'b1;
        meshcfg_open = 1'b0;
        meshcfg_done = 1'b0;
        bssid_shift  = '0;
    endtask

    // Advance the predictor by one byte; on the last byte, queue the frame result.
    task automatic track_frame_byte(input t_in_item it);
        logic [7:0]       b;
        logic [POS_W-1:0] pos_now;
        logic [POS_W-1:0] flen;
        int               k;
        t_out_item        rep;
        b       = it.frame_byte;
        pos_now = pos_cnt;
        if (pos_now >= BSSID_FIRST && pos_now < BSSID_END)
            bssid_shift = {bssid_shift[39:0], b};
        case (walk_phase)
            PH_HEADER: begin
                if (int'(pos_now) + 1 >= ELEMENTS_START)
                    walk_phase = PH_ID;
            end
            PH_ID: begin
                elem_id    = b;
                walk_phase = PH_LEN;
            end
            PH_LEN: begin
                if (elem_id == EID_MESH_ID && !mesh_open && !mesh_done) begin
                    mesh_len   = b;
                    mesh_equal = 1'b1;
                    if (b == 8'd0) mesh_done = 1'b1;
                    else mesh_open = 1'b1;
                end else if (elem_id == EID_MESH_CONFIG && !meshcfg_open && !meshcfg_done) begin
                    if (b == 8'd0) meshcfg_done = 1'b1;
                    else meshcfg_open = 1'b1;
                end
                bytes_left = b;
                if (b == 8'd0) walk_phase = PH_ID;
                else walk_phase = PH_VALUE;
            end
            default: begin
                if (mesh_open) begin
                    k = int'(8'(mesh_len - bytes_left));
                    if (k >= MAX_MESH_ID_BYTES || k >= ID_BANK_BYTES)
                        mesh_equal = 1'b0;
                    else if (cfg_id_bytes[k*8 +: 8] != b)
                        mesh_equal = 1'b0;
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    if (mesh_open) begin
                        mesh_open = 1'b0;
                        mesh_done = 1'b1;
                    end
                    if (meshcfg_open) begin
                        meshcfg_open = 1'b0;
                        meshcfg_done = 1'b1;
                    end
                    walk_phase = PH_ID;
                end
            end
        endcase
        if (pos_cnt < POS_CAP)
            pos_cnt = pos_cnt + 1'b1;
        if (it.last_byte) begin
            flen = (pos_now < POS_CAP) ? pos_now + 1'b1 : POS_CAP;
            rep.mesh_id_found     = mesh_done;
            rep.mesh_id_matches   = mesh_done && mesh_equal &&
                                    int'(cfg_id_len) <= MAX_MESH_ID_BYTES &&
                                    {2'b00, cfg_id_len} == mesh_len;
            rep.mesh_config_found = mesh_done && meshcfg_done;
            rep.bssid_valid       = flen >= BSSID_END;
            rep.bssid             = rep.bssid_valid ? bssid_shift : 48'd0;
            rep.frame_length      = flen;
            expected_reports.push_back(rep);
            clear_frame_state();
        end
    endtask

    // Compare one taken frame result with the oldest owed one.
    task automatic check_frame_result(input t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected frame result %h", got);
        end else begin
            want = expected_reports.pop_front();
            if (got.mesh_id_found !== want.mesh_id_found ||
                got.mesh_id_matches !== want.mesh_id_matches ||
                got.mesh_config_found !== want.mesh_config_found ||
                got.bssid !== want.bssid ||
                got.bssid_valid !== want.bssid_valid ||
                got.frame_length !== want.frame_length) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"frame result mismatch (expected/actual): found %0b/%0b ",
                              "match %0b/%0b config %0b/%0b bssid %h/%h valid %0b/%0b ",
                              "length %0d/%0d"},
                             want.mesh_id_found, got.mesh_id_found,
                             want.mesh_id_matches, got.mesh_id_matches,
                             want.mesh_config_found, got.mesh_config_found,
                             want.bssid, got.bssid, want.bssid_valid, got.bssid_valid,
                             want.frame_length, got.frame_length);
            end
        end
    endtask

    // Rising edge: mirror register writes, predict every byte transfer and
    // check every result transfer. Inputs were set at the falling edge, so
    // the values seen here are the ones the block samples.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_id_len   = '0;
            cfg_id_bytes = '0;
            clear_frame_state();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MESH_ID_LENGTH: cfg_id_len            = i_cfg_data[5:0];
                    CFG_ID_BYTES_0_7:   cfg_id_bytes[63:0]    = i_cfg_data;
                    CFG_ID_BYTES_8_15:  cfg_id_bytes[127:64]  = i_cfg_data;
                    CFG_ID_BYTES_16_23: cfg_id_bytes[191:128] = i_cfg_data;
                    CFG_ID_BYTES_24_31: cfg_id_bytes[255:192] = i_cfg_data;
                    default: ;  // out-of-range index: the block drops it
                endcase
            end
            if (i_valid && !o_stall) begin
                track_frame_byte(i_data);
                void'(pending_bytes.pop_front());
                byte_taken = 1'b1;
            end
            if (o_valid && !i_stall)
                check_frame_result(o_data);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Byte driver: offer the queue head in bursts of random length with random
    // gaps between them. Change the offer only once the current transfer is done,
    // so a stalled byte holds still and valid never looks at stall.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || byte_taken)) begin
            byte_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_valid <= 1'b1;
                i_data  <= pending_bytes[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result sink: stall in a random mode (free, light, pattern or heavy); serve a long
    // hold-off whenever the stimulus asks for one, counted here in cycles.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_asked != holds_given) begin
            holds_given = holds_asked;
            hold_left   = LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode_left  = 64;
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                rx_pattern = 8'($urandom);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:    i_stall <= 1'b0;
                RX_LIGHT:   i_stall <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: i_stall <= rx_pattern[mode_left % 8];
                default:    i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------
    function automatic logic [255:0] random_id();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    task automatic fill_random(input int n);
        repeat (n) frame_buf.push_back(8'($urandom));
    endtask

    task automatic add_element(input logic [7:0] id, input int len);
        frame_buf.push_back(id);
        frame_buf.push_back(8'(len));
        fill_random(len);
    endtask

    // Mesh ID element copying the configured ID; corrupt byte bad_idx if it lies inside.
    task automatic add_mesh_id(input int len, input int bad_idx);
        logic [7:0] b;
        frame_buf.push_back(EID_MESH_ID);
        frame_buf.push_back(8'(len));
        for (int k = 0; k < len; k++) begin
            b = (k < ID_BANK_BYTES) ? cfg_id_bytes[k*8 +: 8] : 8'($urandom);
            if (k == bad_idx)
                b = b ^ 8'($urandom_range(1, 255));
            frame_buf.push_back(b);
        end
    endtask

    // Cut the frame short, keeping at least one byte.
    task automatic trim_frame(input int n);
        repeat (n)
            if (frame_buf.size() > 1) void'(frame_buf.pop_back());
    endtask

    // Move the built frame into the byte queue, marking its final byte.
    task automatic queue_frame();
        t_in_item it;
        foreach (frame_buf[i]) begin
            it.frame_byte = frame_buf[i];
            it.last_byte  = (i == frame_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        phase_items += frame_buf.size();
        phase_frames++;
        frame_buf.delete();
    endtask

    // Mostly well-formed beacons with random elements; some pure noise frames.
    task automatic make_random_frame();
        int len;
        int bad;
        if ($urandom_range(0, 9) == 0) begin
            fill_random($urandom_range(1, 60));
        end else begin
            fill_random(ELEMENTS_START);
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: begin
                        if ($urandom_range(0, 3) != 0) len = cfg_id_len;
                        else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 255);
                        else len = $urandom_range(0, 40);
                        bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : -1;
                        add_mesh_id(len, bad);
                    end
                    3: add_element(EID_MESH_CONFIG, $urandom_range(0, 8));
                    default: add_element(8'($urandom), $urandom_range(0, 12));
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                trim_frame($urandom_range(1, 4));
        end
        queue_frame();
    endtask

    task automatic random_frames();
        phase_items  = 0;
        phase_frames = 0;
        while (phase_items < 40 || phase_frames < 2)
            make_random_frame();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // Load every register, plus one write to an index past the list.
    task automatic load_mesh_id(input logic [5:0] len, input logic [255:0] id);
        write_reg(CFG_ID_BYTES_0_7, id[63:0]);
        write_reg(CFG_ID_BYTES_8_15, id[127:64]);
        write_reg(CFG_ID_BYTES_16_23, id[191:128]);
        write_reg(CFG_ID_BYTES_24_31, id[255:192]);
        write_reg(CFG_MESH_ID_LENGTH, {58'd0, len});
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ID_BYTES_24_31) + 1, STRAY_MAX)),
                  {$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every byte is taken and every result checked, then let the
    // output register and skid entry settle before touching registers.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || expected_reports.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Six-byte ID: frame length edges and the element walk corner cases.
        load_mesh_id(6'd6, random_id());
        frame_buf.push_back(8'hFF);                      // one-byte frame
        queue_frame();
        fill_random(BSSID_END - 1);                      // just too short for a BSSID
        queue_frame();
        fill_random(BSSID_END);                          // just long enough
        queue_frame();
        fill_random(ELEMENTS_START);                     // lone id byte at the end
        frame_buf.push_back(EID_MESH_ID);
        queue_frame();
        fill_random(ELEMENTS_START);                     // match plus mesh config
        add_mesh_id(6, -1);
        add_element(EID_MESH_CONFIG, 2);
        queue_frame();
        fill_random(ELEMENTS_START);                     // mesh config without mesh ID
        add_element(EID_MESH_CONFIG, 0);
        queue_frame();
        fill_random(ELEMENTS_START);                     // later duplicate is ignored
        add_mesh_id(6, 3);
        add_mesh_id(6, -1);
        queue_frame();
        fill_random(ELEMENTS_START);                     // truncated mesh ID element
        add_element(EID_MESH_CONFIG, 4);
        add_mesh_id(6, -1);
        trim_frame(2);
        queue_frame();
        fill_random(ELEMENTS_START);                     // length mismatch
        add_mesh_id(5, -1);
        queue_frame();
        fill_random(ELEMENTS_START);                     // empty mesh ID, empty config
        add_element(EID_MESH_ID, 0);
        add_element(EID_MESH_CONFIG, 0);
        queue_frame();
        wait_idle();

        // Full 32-byte ID of all ones: exact match, last byte wrong, one byte too long.
        load_mesh_id(6'd32, {256{1'b1}});
        fill_random(ELEMENTS_START);
        add_mesh_id(32, -1);
        add_element(EID_MESH_CONFIG, 1);
        queue_frame();
        fill_random(ELEMENTS_START);
        add_mesh_id(32, 31);
        queue_frame();
        fill_random(ELEMENTS_START);
        add_mesh_id(33, -1);
        queue_frame();
        wait_idle();

        // Empty ID of zeros; hold the sink off while tiny frames pile up.
        load_mesh_id(6'd0, 256'd0);
        fill_random(ELEMENTS_START);
        add_element(EID_MESH_ID, 0);
        queue_frame();
        holds_asked++;
        repeat (20) begin
            fill_random($urandom_range(1, 3));
            queue_frame();
        end
        wait_idle();

        // Top length value: never matches, even with an element of that length.
        load_mesh_id(6'd63, {256{1'b1}});
        fill_random(ELEMENTS_START);
        add_mesh_id(63, -1);
        add_element(EID_MESH_CONFIG, 3);
        queue_frame();
        wait_idle();

        // One past the ID bank size, then a random short ID.
        load_mesh_id(6'd33, random_id());
        fill_random(ELEMENTS_START);
        add_mesh_id(33, -1);
        queue_frame();
        wait_idle();

        load_mesh_id(6'($urandom_range(1, 31)), random_id());
        random_frames();
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/bmim_pkg.sv
sv/bmim_parser.sv
sv/beacon_mesh_id_matcher.sv
bench/tb.sv
